// File: hdl/icle_pkg.sv
package icle_pkg;
  localparam int PoolEntries = 256;
  localparam int Buckets = 64;
  localparam int EntW = $clog2(PoolEntries);
  localparam int PtrW = EntW + 1;
  localparam int BktW = $clog2(Buckets);
  localparam logic [PtrW-1:0] NilPtr = PtrW'(PoolEntries);

  localparam logic [1:0] OpLookup = 2'd0;
  localparam logic [1:0] OpRelease = 2'd1;
  localparam logic [1:0] OpDestroy = 2'd2;
  localparam logic [1:0] OpFree = 2'd3;

  localparam logic [1:0] StHit = 2'd0;
  localparam logic [1:0] StNew = 2'd1;
  localparam logic [1:0] StNone = 2'd2;
  localparam logic [1:0] StRefused = 2'd3;

  localparam logic [1:0] PlFree = 2'd0;
  localparam logic [1:0] PlHashed = 2'd1;
  localparam logic [1:0] PlDetached = 2'd2;

  function automatic logic [4:0] hash_prime(input logic [2:0] sel);
    logic [4:0] p;
    case (sel)
      3'd0: p = 5'd3;
      3'd1: p = 5'd5;
      3'd2: p = 5'd7;
      3'd3: p = 5'd11;
      3'd4: p = 5'd13;
      3'd5: p = 5'd17;
      3'd6: p = 5'd19;
      default: p = 5'd23;
    endcase
    return p;
  endfunction
endpackage

// File: hdl/inode_cache_lookup_engine_unit.sv
// Inode cache engine: one item (lookup, release, destroy or free) is taken at a time and
// gives one result. After reset a clearing pass over all 256 entries initialises the entry
// table; ready stays low meanwhile. Entry fields are read into registers before they are
// checked. A lookup that hits stops at the matching entry of its bucket chain, and a miss
// walks the chain and then takes an entry from the free list. With the free list empty,
// the eviction scan visits the buckets, walks their entries and unlinks the first one with
// no references. A destroy that succeeds unlinks its entry. A result held back by the
// receiver adds its wait.
module inode_cache_lookup_engine_unit
  import icle_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [15:0] device_id,
  input  logic [31:0] inode_number,
  input  logic [7:0]  entry_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [7:0]  result_entry,
  output logic [7:0]  ref_count
);
  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_HASH, S_HEAD, S_RD, S_CHK, S_FREE_RD, S_FREE_CHK,
    S_EV_HEAD, S_EV_RD, S_EV_CHK, S_UNL_N, S_UNL_P, S_INS_OLD, S_INS,
    S_IDX_RD, S_IDX_CHK, S_OUT
  } state_t;

  // Entry memory fields are kept in parallel arrays.
  logic [15:0]     tdev [PoolEntries];
  logic [31:0]     tino [PoolEntries];
  logic [7:0]      trefs [PoolEntries];
  logic [PtrW-1:0] tnext [PoolEntries];
  logic [PtrW-1:0] tprev [PoolEntries];
  logic [BktW-1:0] tbkt [PoolEntries];
  logic [1:0]      tplace [PoolEntries];
  logic [PtrW-1:0] bhead [Buckets];

  state_t state, ret;
  logic [1:0] op;
  logic [15:0] dev;
  logic [31:0] ino;
  logic [7:0] idx;
  logic [BktW-1:0] h, sb;
  logic [PtrW-1:0] cur, free_head, headv, newe;
  logic [15:0] r_dev;
  logic [31:0] r_ino, prod;
  logic [7:0] r_refs;
  logic [PtrW-1:0] r_next, r_prev;
  logic [BktW-1:0] r_bkt;
  logic [1:0] r_place;
  logic [EntW:0] clr;
  logic [EntW:0] steps;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      free_head <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          trefs[clr[EntW-1:0]] <= '0;
          tnext[clr[EntW-1:0]] <= PtrW'(clr) + 1'b1;
          tprev[clr[EntW-1:0]] <= NilPtr;
          tplace[clr[EntW-1:0]] <= PlFree;
          if (clr < (EntW+1)'(Buckets)) bhead[clr[BktW-1:0]] <= NilPtr;
          clr <= clr + 1'b1;
          if (clr == (EntW+1)'(PoolEntries - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            op <= opcode; dev <= device_id; ino <= inode_number; idx <= entry_index;
            prod <= 32'(hash_prime(device_id[2:0])) * (inode_number + 32'd1);
            if (opcode == OpLookup) state <= S_HASH;
            else if (PtrW'(entry_index) >= PtrW'(PoolEntries)) begin
              status <= StRefused; result_entry <= entry_index; ref_count <= '0;
              state <= S_OUT;
            end else begin
              cur <= PtrW'(entry_index);
              state <= S_IDX_RD;
            end
          end
        end
        S_HASH: begin
          h <= prod[BktW-1:0];
          state <= S_HEAD;
        end
        S_HEAD: begin
          cur <= bhead[h];
          headv <= bhead[h];
          steps <= '0;
          state <= S_RD;
        end
        S_RD: begin
          if (cur == NilPtr || steps == (EntW+1)'(PoolEntries)) state <= S_FREE_RD;
          else begin
            r_dev <= tdev[cur[EntW-1:0]]; r_ino <= tino[cur[EntW-1:0]];
            r_refs <= trefs[cur[EntW-1:0]]; r_next <= tnext[cur[EntW-1:0]];
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (r_dev == dev && r_ino == ino) begin
            if (r_refs != 8'hff) begin
              trefs[cur[EntW-1:0]] <= r_refs + 1'b1;
              ref_count <= r_refs + 1'b1;
            end else ref_count <= r_refs;
            status <= StHit; result_entry <= cur[EntW-1:0];
            state <= S_OUT;
          end else begin
            cur <= r_next; steps <= steps + 1'b1;
            state <= S_RD;
          end
        end
        S_FREE_RD: begin
          if (free_head != NilPtr) begin
            newe <= free_head;
            free_head <= tnext[free_head[EntW-1:0]];
            state <= S_INS_OLD;
          end else begin
            sb <= '0;
            state <= S_EV_HEAD;
          end
        end
        S_EV_HEAD: begin
          cur <= bhead[sb];
          steps <= '0;
          state <= S_EV_RD;
        end
        S_EV_RD: begin
          if (cur == NilPtr || steps == (EntW+1)'(PoolEntries)) begin
            if (sb == BktW'(Buckets - 1)) begin
              status <= StNone; result_entry <= '0; ref_count <= '0;
              state <= S_OUT;
            end else begin
              sb <= sb + 1'b1;
              state <= S_EV_HEAD;
            end
          end else begin
            r_refs <= trefs[cur[EntW-1:0]]; r_next <= tnext[cur[EntW-1:0]];
            r_prev <= tprev[cur[EntW-1:0]]; r_bkt <= tbkt[cur[EntW-1:0]];
            state <= S_EV_CHK;
          end
        end
        S_EV_CHK: begin
          if (r_refs == '0) begin
            newe <= cur; ret <= S_INS_OLD;
            state <= S_UNL_N;
          end else begin
            cur <= r_next; steps <= steps + 1'b1;
            state <= S_EV_RD;
          end
        end
        // Unlink cur using r_next, r_prev and r_bkt.
        S_UNL_N: begin
          if (r_next != NilPtr) tprev[r_next[EntW-1:0]] <= r_prev;
          state <= S_UNL_P;
        end
        S_UNL_P: begin
          if (r_prev != NilPtr) tnext[r_prev[EntW-1:0]] <= r_next;
          else bhead[r_bkt] <= r_next;
          tnext[cur[EntW-1:0]] <= NilPtr;
          tprev[cur[EntW-1:0]] <= NilPtr;
          state <= ret;
        end
        S_INS_OLD: begin
          headv <= bhead[h];
          state <= S_INS;
        end
        S_INS: begin
          tdev[newe[EntW-1:0]] <= dev; tino[newe[EntW-1:0]] <= ino;
          tbkt[newe[EntW-1:0]] <= h; tprev[newe[EntW-1:0]] <= NilPtr;
          tnext[newe[EntW-1:0]] <= headv; trefs[newe[EntW-1:0]] <= 8'd1;
          tplace[newe[EntW-1:0]] <= PlHashed;
          if (headv != NilPtr) tprev[headv[EntW-1:0]] <= newe;
          bhead[h] <= newe;
          status <= StNew; result_entry <= newe[EntW-1:0]; ref_count <= 8'd1;
          state <= S_OUT;
        end
        S_IDX_RD: begin
          r_refs <= trefs[cur[EntW-1:0]]; r_next <= tnext[cur[EntW-1:0]];
          r_prev <= tprev[cur[EntW-1:0]]; r_bkt <= tbkt[cur[EntW-1:0]];
          r_place <= tplace[cur[EntW-1:0]];
          state <= S_IDX_CHK;
        end
        S_IDX_CHK: begin
          result_entry <= idx;
          case (op)
            OpRelease: begin
              if (r_place == PlHashed && r_refs != '0) begin
                trefs[cur[EntW-1:0]] <= r_refs - 1'b1;
                status <= StHit; ref_count <= r_refs - 1'b1;
              end else begin
                status <= StRefused; ref_count <= r_refs;
              end
              state <= S_OUT;
            end
            OpDestroy: begin
              if (r_place == PlHashed && r_refs == 8'd1) begin
                trefs[cur[EntW-1:0]] <= '0;
                tplace[cur[EntW-1:0]] <= PlDetached;
                status <= StHit; ref_count <= '0;
                ret <= S_OUT;
                state <= S_UNL_N;
              end else begin
                status <= StRefused; ref_count <= r_refs;
                state <= S_OUT;
              end
            end
            default: begin
              if (r_place == PlDetached) begin
                tnext[cur[EntW-1:0]] <= free_head;
                tprev[cur[EntW-1:0]] <= NilPtr;
                free_head <= cur;
                trefs[cur[EntW-1:0]] <= '0;
                tplace[cur[EntW-1:0]] <= PlFree;
                status <= StHit; ref_count <= '0;
              end else begin
                status <= StRefused; ref_count <= r_refs;
              end
              state <= S_OUT;
            end
          endcase
        end
        S_OUT: begin
          if (out_valid && out_ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end else begin
            out_valid <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
